/* rtl/lfg_pkg.sv */
// Shared types and constants for the lagged Fibonacci (31,3) generator.
// No dependencies; used by every module in rtl/.
package lfg_pkg;

  localparam int unsigned PoolDepth   = 34;
  localparam int unsigned AddrW       = 6;
  localparam int unsigned WordW       = 32;
  localparam int unsigned ValueW      = 31;
  localparam int unsigned LagShort    = 3;
  localparam int unsigned LagLong     = 31;
  localparam int unsigned MulW        = 15;
  localparam int unsigned ProdW       = MulW + WordW;
  localparam int unsigned WarmupDraws = 310;
  localparam int unsigned CntW        = 9;

  localparam logic [MulW-1:0]  LehmerMul = MulW'(16807);
  localparam logic [WordW-1:0] LehmerMod = 32'h7FFF_FFFF;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_FOLD = 2'd1,
    ALU_MUL  = 2'd2
  } alu_op_e;

  typedef struct packed {
    alu_op_e op;
    word_t   opa;
    word_t   opb;
  } alu_req_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } pool_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic              seeded;
  } res_t;

endpackage

/* rtl/lfg_pool.sv */
// 34-word ring memory: one write port, two registered read ports.
// Per-entry valid bits make unwritten words read as zero after reset. Uses lfg_pkg.
module lfg_pool (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfg_pkg::pool_ctl_t ctl_i,
  output lfg_pkg::word_t    rd_a_o,
  output lfg_pkg::word_t    rd_b_o
);
  import lfg_pkg::*;

  word_t                mem [PoolDepth];
  logic [PoolDepth-1:0] valid_q;
  word_t                rd_a_q;
  word_t                rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.we) begin
      valid_q[ctl_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[ctl_i.waddr] <= ctl_i.wdata;
    end
    rd_a_q <= valid_q[ctl_i.raddr_a] ? mem[ctl_i.raddr_a] : '0;
    rd_b_q <= valid_q[ctl_i.raddr_b] ? mem[ctl_i.raddr_b] : '0;
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

/* rtl/lfg_alu.sv */
// Shared arithmetic unit: one 32-bit adder serves the lagged sum and the
// mod 2^31-1 fold; a registered 15x32 multiplier forms the Lehmer product. Uses lfg_pkg.
module lfg_alu (
  input  logic              clk_i,
  input  lfg_pkg::alu_req_t req_i,
  output lfg_pkg::word_t    res_o
);
  import lfg_pkg::*;

  logic [ProdW-1:0] prod_q;
  word_t            add_a;
  word_t            add_b;
  word_t            sum;
  word_t            folded;

  // product register, loaded only on a multiply step
  always_ff @(posedge clk_i) begin
    if (req_i.op == ALU_MUL) begin
      prod_q <= ProdW'(LehmerMul) * ProdW'(req_i.opa);
    end
  end

  always_comb begin
    case (req_i.op)
      ALU_FOLD: begin
        // p mod (2^31-1) == (p >> 31) + (p & (2^31-1)), then one correction
        add_a = WordW'(prod_q[ProdW-1:ValueW]);
        add_b = {1'b0, prod_q[ValueW-1:0]};
      end
      default: begin
        add_a = req_i.opa;
        add_b = req_i.opb;
      end
    endcase
    sum    = add_a + add_b;
    folded = (sum >= LehmerMod) ? sum - LehmerMod : sum;
    res_o  = (req_i.op == ALU_FOLD) ? folded : sum;
  end

endmodule

/* rtl/lfg_seq.sv */
// Sequencer: walks draws, the Lehmer fill, the tail copy and the warm-up
// draws, steering the ring memory and the shared ALU. Uses lfg_pkg.
module lfg_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_mode_i,
  input  lfg_pkg::word_t     in_seed_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output lfg_pkg::res_t      res_o,
  output lfg_pkg::pool_ctl_t pool_ctl_o,
  input  lfg_pkg::word_t     rd_a_i,
  input  lfg_pkg::word_t     rd_b_i,
  output lfg_pkg::alu_req_t  alu_req_o,
  input  lfg_pkg::word_t     alu_res_i
);
  import lfg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DRD  = 4'd1;
  localparam logic [3:0] S_DADD = 4'd2;
  localparam logic [3:0] S_SEED = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_FOLD = 4'd5;
  localparam logic [3:0] S_CRD  = 4'd6;
  localparam logic [3:0] S_CWR  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam addr_t LastIdx  = AddrW'(PoolDepth - 1);
  localparam addr_t FillLast = AddrW'(LagLong - 1);

  logic [3:0]        state_q, state_d;
  addr_t             idx_q, idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              warm_q, warm_d;
  word_t             x_q, x_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              seeded_q, seeded_d;
  addr_t             idx_inc;

  assign idx_inc = (idx_q == LastIdx) ? '0 : idx_q + AddrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      warm_q   <= 1'b0;
      seeded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      warm_q   <= warm_d;
      seeded_q <= seeded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    val_q <= val_d;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    warm_d   = warm_q;
    x_d      = x_q;
    val_d    = val_q;
    seeded_d = seeded_q;

    // lagged read addresses, modulo the ring depth
    pool_ctl_o.raddr_a = (idx_q >= AddrW'(LagShort)) ? idx_q - AddrW'(LagShort)
                                                     : idx_q + AddrW'(PoolDepth - LagShort);
    pool_ctl_o.raddr_b = (idx_q >= AddrW'(LagLong)) ? idx_q - AddrW'(LagLong)
                                                    : idx_q + AddrW'(PoolDepth - LagLong);

    pool_ctl_o.we    = 1'b0;
    pool_ctl_o.waddr = idx_q;
    pool_ctl_o.wdata = alu_res_i;

    alu_req_o.op  = ALU_ADD;
    alu_req_o.opa = rd_a_i;
    alu_req_o.opb = rd_b_i;

    in_ready_o   = 1'b0;
    res_o.valid  = 1'b0;
    res_o.value  = val_q;
    res_o.seeded = seeded_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d = in_seed_i;
          if (in_mode_i) begin
            state_d = S_SEED;
          end else begin
            idx_d   = idx_inc;
            warm_d  = 1'b0;
            state_d = S_DRD;
          end
        end
      end
      S_DRD: begin
        state_d = S_DADD;
      end
      S_DADD: begin
        pool_ctl_o.we = 1'b1;
        if (warm_q) begin
          if (cnt_q == '0) begin
            val_d    = '0;
            seeded_d = 1'b1;
            state_d  = S_OUT;
          end else begin
            cnt_d   = cnt_q - CntW'(1);
            idx_d   = idx_inc;
            state_d = S_DRD;
          end
        end else begin
          val_d    = alu_res_i[WordW-1:1];
          seeded_d = 1'b0;
          state_d  = S_OUT;
        end
      end
      S_SEED: begin
        pool_ctl_o.we    = 1'b1;
        pool_ctl_o.waddr = '0;
        pool_ctl_o.wdata = x_q;
        idx_d            = AddrW'(1);
        state_d          = S_MUL;
      end
      S_MUL: begin
        alu_req_o.op  = ALU_MUL;
        alu_req_o.opa = x_q;
        state_d       = S_FOLD;
      end
      S_FOLD: begin
        alu_req_o.op  = ALU_FOLD;
        pool_ctl_o.we = 1'b1;
        x_d           = alu_res_i;
        idx_d         = idx_q + AddrW'(1);
        state_d       = (idx_q == FillLast) ? S_CRD : S_MUL;
      end
      S_CRD: begin
        state_d = S_CWR;
      end
      S_CWR: begin
        // tail words mirror words 0 to 2
        pool_ctl_o.we    = 1'b1;
        pool_ctl_o.wdata = rd_b_i;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          cnt_d   = CntW'(WarmupDraws - 1);
          warm_d  = 1'b1;
          state_d = S_DRD;
        end else begin
          idx_d   = idx_q + AddrW'(1);
          state_d = S_CRD;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/lagged_fibonacci_random_generator.sv */
// Lagged Fibonacci (31,3) generator top level: stream ports, output register.
// Draw: read, add, output; the next word is taken once the result is registered.
// Reseed: seed to word 0, multiply/fold fills 1 to 30, words 31 to 33 copy 0 to 2,
// then 310 warm-up draws, all through one write port and the shared adder.
// Reset (async, active low) clears the sequencer, the index and the valid bits, so
// the ring reads as all zeros; s_axis_tready is low while a word is in progress.
module lagged_fibonacci_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed
  input  logic        s_axis_tuser,   // [0] mode: 0 draw, 1 reseed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] value, [31] zero fill
  output logic        m_axis_tuser    // [0] seeded
);
  import lfg_pkg::*;

  pool_ctl_t         pool_ctl;
  alu_req_t          alu_req;
  res_t              res;
  word_t             rd_a;
  word_t             rd_b;
  word_t             alu_res;
  logic              out_free;

  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_seeded_q;

  // output slot can take a new word when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  lfg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_seed_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .res_o      (res),
    .pool_ctl_o (pool_ctl),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .alu_req_o  (alu_req),
    .alu_res_i  (alu_res)
  );

  lfg_pool u_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pool_ctl),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  lfg_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_value_q  <= res.value;
      out_seeded_q <= res.seeded;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_value_q};
  assign m_axis_tuser  = out_seeded_q;

  // accepting a word always takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sequencer still ready after accepting a word");

  // a finished result never overwrites a word still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result issued while output slot is occupied");

  // reseed acknowledgment carries a zero value
  a_seed_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("reseed acknowledgment with nonzero value");

endmodule

/* verif/lagged_fibonacci_random_generator_tb.sv */
// Self-checking testbench for the lagged Fibonacci (31,3) random number generator.
// Depends on rtl/lfg_pkg.sv and rtl/lagged_fibonacci_random_generator.sv; carries its own
// ring predictor and compares every output word against it.
module lagged_fibonacci_random_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfg_pkg::*;

  localparam logic        MODE_DRAW   = 1'b0;
  localparam logic        MODE_RESEED = 1'b1;
  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxPrinted  = 100;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned HoldCycles  = 1500;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              seeded;
  } number_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_pattern_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] seed
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [30:0] value, [31] zero fill
  logic        m_axis_tuser;         // [0] seeded

  // predictor state: private copy of the ring and its index
  word_t       ring_copy [PoolDepth];
  int unsigned ring_pos;

  number_t     pending_numbers_q [$];
  int unsigned error_count   = 0;
  int unsigned checked_count = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_request  = 0;

  lagged_fibonacci_random_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  // one additive step: new word = word 3 back + word 31 back, 32-bit wrap
  function automatic word_t step_ring();
    int unsigned pos;
    word_t       sum;
    pos      = (ring_pos + 1) % PoolDepth;
    ring_pos = pos;
    sum      = ring_copy[(pos + PoolDepth - LagShort) % PoolDepth] +
               ring_copy[(pos + PoolDepth - LagLong) % PoolDepth];
    ring_copy[pos] = sum;
    return sum;
  endfunction

  function automatic void refill_ring(word_t seed);
    logic [63:0] prod;
    ring_copy[0] = seed;
    // Lehmer fill on the full unsigned 32-bit predecessor
    for (int i = 1; i < LagLong; i++) begin
      prod         = 64'(LehmerMul) * 64'(ring_copy[i-1]);
      ring_copy[i] = word_t'(prod % 64'(LehmerMod));
    end
    for (int k = 0; k < PoolDepth - LagLong; k++) begin
      ring_copy[LagLong + k] = ring_copy[k];
    end
    ring_pos = PoolDepth - 1;
    repeat (WarmupDraws) void'(step_ring());
  endfunction

  function automatic number_t predict_number(logic mode, word_t seed);
    number_t n;
    word_t   sum;
    if (mode == MODE_RESEED) begin
      refill_ring(seed);
      n.value  = '0;
      n.seeded = 1'b1;
    end else begin
      sum      = step_ring();
      n.value  = sum[WordW-1:1];
      n.seeded = 1'b0;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("mismatch (%s) at output word %0d: expected %h, got %h",
               what, checked_count, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_numbers
    number_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_numbers_q.size() == 0) begin
        report_mismatch("unexpected word", '0, {m_axis_tuser, m_axis_tdata});
      end else begin
        want = pending_numbers_q.pop_front();
        if (m_axis_tdata[ValueW-1:0] !== want.value) begin
          report_mismatch("value", want.value, m_axis_tdata[ValueW-1:0]);
        end
        if (m_axis_tuser !== want.seeded) begin
          report_mismatch("seeded", want.seeded, m_axis_tuser);
        end
        if (m_axis_tdata[WordW-1:ValueW] !== '0) begin
          report_mismatch("fill", '0, m_axis_tdata[WordW-1:ValueW]);
        end
      end
      checked_count++;
    end
  end

  // ---------------------------------------------------------------- receiver

  // Own stall pattern, switched at the end of each random phase; a long hold-off
  // request overrides it and is counted down here.
  initial begin : drive_ready
    rx_pattern_e pattern;
    int unsigned phase_left;
    int unsigned hold_left;
    pattern    = RX_ALWAYS;
    phase_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          pattern    = rx_pattern_e'($urandom_range(0, 3));
          phase_left = $urandom_range(32, 300);
        end
        phase_left--;
        case (pattern)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 4) != 0);
          default:   m_axis_tready <= (cycle_count % 7 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // Offers one word, waits for the handshake, records the expected number,
  // then either keeps tvalid up for the next word or opens a gap.
  task automatic send_word(logic mode, word_t seed);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seed;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_numbers_q.push_back(predict_number(mode, seed));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom;
        s_axis_tuser  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic word_t pick_seed();
    word_t edges [5];
    edges = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(0, 7))
      0:       return edges[$urandom_range(0, 4)];
      1:       return word_t'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // ring is all zeros out of reset, so draws give zero
  task automatic test_unseeded_draws();
    send_word(MODE_DRAW, 32'h0000_0000);
    send_word(MODE_DRAW, 32'hFFFF_FFFF);
    send_word(MODE_DRAW, $urandom);
  endtask

  // zero seed, one, the modulus itself, top bit set, all ones; seed field on
  // draws carries junk that must be ignored
  task automatic test_edge_seeds();
    word_t seeds [5];
    seeds = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    foreach (seeds[i]) begin
      send_word(MODE_RESEED, seeds[i]);
      send_word(MODE_DRAW, ~seeds[i]);
      send_word(MODE_DRAW, $urandom);
    end
  endtask

  // receiver holds off while words keep coming; input must back up and stall
  task automatic test_output_stall();
    hold_request = HoldCycles;
    send_word(MODE_RESEED, $urandom);
    repeat (24) send_word(MODE_DRAW, $urandom);
  endtask

  // mostly long draw runs between occasional reseeds
  task automatic test_random_stream(int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) begin
        send_word(MODE_RESEED, pick_seed());
      end else begin
        send_word(MODE_DRAW, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------- run

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : run_tests
    foreach (ring_copy[i]) ring_copy[i] = '0;
    ring_pos = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unseeded_draws();
    test_edge_seeds();
    test_output_stall();
    test_random_stream(RandomItems);
    s_axis_tvalid <= 1'b0;

    while (pending_numbers_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* lagged_fibonacci_random_generator.f */
rtl/lfg_pkg.sv
rtl/lfg_pool.sv
rtl/lfg_alu.sv
rtl/lfg_seq.sv
rtl/lagged_fibonacci_random_generator.sv
verif/lagged_fibonacci_random_generator_tb.sv
